FILE: hdl/fgnh_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fgnh_pkg
// Shared types, fixed-point constants and helper functions of the fractal
// gradient-noise height generator.
// ============================================================================
package fgnh_pkg;

  // Fixed-point format and grid limits.
  localparam int FRAC_BITS   = 16;
  localparam int GRID_SIZE   = 4096;
  localparam int OCTAVES_DEF = 3;

  localparam longint FX_ONE     = longint'(1) << FRAC_BITS;
  localparam longint FREQ_MUL   = ((longint'(18) << FRAC_BITS) + 5) / 10;
  localparam longint AMP_MUL    = ((longint'(4) << FRAC_BITS) + 5) / 10;
  localparam longint HEIGHT_MUL = (longint'(51) << FRAC_BITS) / 4;
  localparam longint HEIGHT_MAX = 1671168;

  localparam logic [15:0] COORD_SCALE_RST = 16'd3277;

  // Widths: signed working value, Q12.16 coordinate, Q8.16 lattice position.
  localparam int FXW = 22;
  localparam int CW  = 28;
  localparam int LW  = 24;
  localparam int HW  = 21;
  localparam int PW  = 48;

  typedef logic signed [FXW-1:0] fx_t;
  typedef logic [CW-1:0]         coord_t;
  typedef logic [LW-1:0]         lat_t;
  typedef logic [HW-1:0]         height_t;
  typedef logic signed [PW-1:0]  prod_t;

  // Table load beat that travels down the pipeline next to the data.
  typedef struct packed {
    logic       ld;
    logic [7:0] idx;
    logic [7:0] val;
  } load_t;

  // Frequency of octave k: starts at one and is scaled by 1.8 per octave.
  function automatic longint oct_freq(input int k);
    longint f;
    f = FX_ONE;
    for (int i = 0; i < k; i++) begin
      f = (f * FREQ_MUL) >> FRAC_BITS;
    end
    return f;
  endfunction

  // Weight of octave k: starts at one and is scaled by 0.4 per octave.
  function automatic longint oct_amp(input int k);
    longint a;
    a = FX_ONE;
    for (int i = 0; i < k; i++) begin
      a = (a * AMP_MUL) >> FRAC_BITS;
    end
    return a;
  endfunction

  // Sum of the weights of the first n octaves.
  function automatic longint amp_sum(input int n);
    longint s;
    s = 0;
    for (int i = 0; i < n; i++) begin
      s = s + oct_amp(i);
    end
    return s;
  endfunction

  // Drops the fraction bits of a signed product, rounding toward zero.
  function automatic fx_t trunc_fx(input prod_t p);
    prod_t adj;
    adj = p + (p[PW-1] ? ((prod_t'(1) <<< FRAC_BITS) - prod_t'(1)) : prod_t'(0));
    return fx_t'(adj >>> FRAC_BITS);
  endfunction

endpackage

FILE: hdl/fractal_gradient_noise_height.sv
`timescale 1ns / 1ps
// ============================================================================
// fractal_gradient_noise_height
// Fractal gradient-noise terrain height: loads the permutation table and
// evaluates a multi-octave noise height for one grid cell per clock.
// ============================================================================
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  input   | in_req_type in_entry_* in_grid_row/col  | start high, busy low
//  config  | cfg_data (coord_scale)                  | cfg_valid & cfg_ready
//  result  | out_height                              | out_valid, one cycle
//
//  A new beat is taken every clock cycle while busy is low. A height leaves
//  after its beat has passed two entry stages, ten stages of the octave lanes
//  (which run side by side) and six normalization stages.
//  Table loads travel down the lanes and update each table copy at the stage
//  that reads it, so evaluations see loads in beat order.
//  Busy is high only in reset and the cycle after it; the pipeline never stalls.
//  Synchronous active-low reset clears all valid bits and restores the
//  identity table and the default scale.
// ============================================================================
module fractal_gradient_noise_height #(
  parameter int OCTAVE_COUNT = fgnh_pkg::OCTAVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [7:0]            in_entry_index,
  input  logic [7:0]            in_entry_value,
  input  logic [11:0]           in_grid_row,
  input  logic [11:0]           in_grid_col,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data,
  output logic                  out_valid,
  output fgnh_pkg::height_t     out_height
);
  import fgnh_pkg::*;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Configuration register.
  logic [15:0] coord_scale_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_scale_r <= COORD_SCALE_RST;
      busy_r        <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        coord_scale_r <= cfg_data;
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  // Entry stage: capture the beat and drop cells outside the grid.
  logic        acc, in_range;
  logic        vld1_r;
  load_t       ld1_r, ld1_nxt;
  logic [11:0] row1_r, col1_r;

  assign acc      = start && !busy_r;
  assign in_range = (17'(in_grid_row) < 17'(GRID_SIZE)) &&
                    (17'(in_grid_col) < 17'(GRID_SIZE));
  assign ld1_nxt  = '{ld: acc && (in_req_type == REQ_LOAD),
                      idx: in_entry_index, val: in_entry_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      ld1_r  <= '0;
    end else begin
      vld1_r <= acc && (in_req_type == REQ_EVAL) && in_range;
      ld1_r  <= ld1_nxt;
    end
    row1_r <= in_grid_row;
    col1_r <= in_grid_col;
  end

  // Coordinate stage: cell times Q0.16 scale, giving a Q12.16 coordinate.
  logic [CW+FRAC_BITS-1:0] xs, ys;
  coord_t x2_r, y2_r;
  logic   vld2_r;
  load_t  ld2_r;

  assign xs = (CW+FRAC_BITS)'(row1_r) * (CW+FRAC_BITS)'(coord_scale_r);
  assign ys = (CW+FRAC_BITS)'(col1_r) * (CW+FRAC_BITS)'(coord_scale_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      ld2_r  <= '0;
    end else begin
      vld2_r <= vld1_r;
      ld2_r  <= ld1_r;
    end
    x2_r <= CW'((xs << FRAC_BITS) >> 16);
    y2_r <= CW'((ys << FRAC_BITS) >> 16);
  end

  // Octave lanes, one per octave.
  logic [OCTAVE_COUNT-1:0] lane_vld;
  fx_t                     lane_term [OCTAVE_COUNT];

  for (genvar g = 0; g < OCTAVE_COUNT; g++) begin : g_lane
    fgnh_octave #(
      .OCT_IDX (g)
    ) u_octave (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld2_r),
      .in_load  (ld2_r),
      .in_x     (x2_r),
      .in_y     (y2_r),
      .term_vld (lane_vld[g]),
      .term     (lane_term[g])
    );
  end

  // Normalization and height mapping.
  fgnh_norm #(
    .OCTAVE_COUNT (OCTAVE_COUNT)
  ) u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_vld   (lane_vld[0]),
    .term       (lane_term),
    .height_vld (out_valid),
    .height     (out_height)
  );

`ifndef ASSERT_OFF
  // Every height comes from an accepted evaluation beat.
  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_req_type, 18))
    else $error("height strobe without a matching evaluation beat");

  // All octave lanes carry the same beat.
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_vld == '0) || (lane_vld == '1))
    else $error("octave lanes out of step");

  // Every height passes through the normalization path from a valid lane output.
  a_norm_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(lane_vld[0], 6))
    else $error("normalization stage lost alignment");
`endif

endmodule

FILE: hdl/fgnh_perm_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// fgnh_perm_mem
// One copy of the 256-entry permutation table with two registered read
// ports. An entry never written reads as its own index.
// ============================================================================
module fgnh_perm_mem (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [7:0] rd_addr0,
  input  logic [7:0] rd_addr1,
  output logic [7:0] rd_data0,
  output logic [7:0] rd_data1
);

  logic [7:0]   mem [256];
  logic [255:0] wvld_r;
  logic [7:0]   dat0_r, dat1_r, adr0_r, adr1_r;
  logic         hit0_r, hit1_r;

  // Storage array and its read data registers.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    dat0_r <= mem[rd_addr0];
    dat1_r <= mem[rd_addr1];
    adr0_r <= rd_addr0;
    adr1_r <= rd_addr1;
  end

  // Written flags; reset returns the table to the identity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
      hit0_r <= 1'b0;
      hit1_r <= 1'b0;
    end else begin
      if (wr_en) begin
        wvld_r[wr_addr] <= 1'b1;
      end
      hit0_r <= wvld_r[rd_addr0];
      hit1_r <= wvld_r[rd_addr1];
    end
  end

  assign rd_data0 = hit0_r ? dat0_r : adr0_r;
  assign rd_data1 = hit1_r ? dat1_r : adr1_r;

endmodule

FILE: hdl/fgnh_octave.sv
`timescale 1ns / 1ps
// ============================================================================
// fgnh_octave
// One octave lane: lattice position, table hashing, fade curves, gradient
// blend and weighting. Ten register stages; table loads pass down the stages
// ahead of the table copies and update each copy at the stage that reads it.
// ============================================================================
module fgnh_octave #(
  parameter int OCT_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  fgnh_pkg::load_t in_load,
  input  fgnh_pkg::coord_t in_x,
  input  fgnh_pkg::coord_t in_y,
  output logic            term_vld,
  output fgnh_pkg::fx_t   term
);
  import fgnh_pkg::*;

  localparam longint FREQ = oct_freq(OCT_IDX);
  localparam longint AMP  = oct_amp(OCT_IDX);
  localparam int     MW   = CW + 24;
  localparam fx_t    ONE  = fx_t'(FX_ONE);
  localparam fx_t    TEN  = fx_t'(10 * FX_ONE);

  // Gradient selectors taken from the two low hash bits.
  localparam logic [1:0] GRAD_PP = 2'd0;
  localparam logic [1:0] GRAD_NP = 2'd1;
  localparam logic [1:0] GRAD_PN = 2'd2;

  function automatic fx_t grad(input logic [7:0] h, input fx_t gx, input fx_t gy);
    fx_t r;
    case (h[1:0])
      GRAD_PP: r = gx + gy;
      GRAD_NP: r = gy - gx;
      GRAD_PN: r = gx - gy;
      default: r = -gx - gy;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sq_frac(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    p = 32'(a) * 32'(b);
    return p[FRAC_BITS +: 16];
  endfunction

  function automatic prod_t fade_inner(input logic [15:0] t);
    prod_t ts;
    ts = $signed(PW'(t));
    return ts * (ts * prod_t'(6) - prod_t'(15) * prod_t'(FX_ONE));
  endfunction

  // Stage 1: scale the coordinate by the octave frequency.
  logic [MW-1:0] xf, yf;
  lat_t  cx_r, cy_r;
  logic  vld1_r;
  load_t ld1_r;

  assign xf = MW'(in_x) * MW'(FREQ);
  assign yf = MW'(in_y) * MW'(FREQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      ld1_r  <= '0;
    end else begin
      vld1_r <= in_vld;
      ld1_r  <= in_load;
    end
    cx_r <= xf[FRAC_BITS +: LW];
    cy_r <= yf[FRAC_BITS +: LW];
  end

  // Stage 2: read the two column hashes, start both fade curves.
  logic [7:0]  xi, pa, pb;
  logic [15:0] fx1, fy1;
  logic [7:0]  yi2_r;
  logic [15:0] fx2_r, fy2_r, ttx2_r, tty2_r;
  prod_t       ptx2_r, pty2_r;
  logic        vld2_r;
  load_t       ld2_r;

  assign xi  = cx_r[FRAC_BITS +: 8];
  assign fx1 = cx_r[FRAC_BITS-1:0];
  assign fy1 = cy_r[FRAC_BITS-1:0];

  fgnh_perm_mem u_perm_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ld1_r.ld),
    .wr_addr  (ld1_r.idx),
    .wr_data  (ld1_r.val),
    .rd_addr0 (xi),
    .rd_addr1 (xi + 8'd1),
    .rd_data0 (pa),
    .rd_data1 (pb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      ld2_r  <= '0;
    end else begin
      vld2_r <= vld1_r;
      ld2_r  <= ld1_r;
    end
    yi2_r  <= cy_r[FRAC_BITS +: 8];
    fx2_r  <= fx1;
    fy2_r  <= fy1;
    ttx2_r <= sq_frac(fx1, fx1);
    tty2_r <= sq_frac(fy1, fy1);
    ptx2_r <= fade_inner(fx1);
    pty2_r <= fade_inner(fy1);
  end

  // Stage 3: read the four corner hashes, finish the cubic and inner terms.
  logic [7:0]  ha, hb, haa, hab, hba, hbb;
  logic [15:0] fx3_r, fy3_r, t3x3_r, t3y3_r;
  fx_t         inx3_r, iny3_r;
  logic        vld3_r;

  assign ha = pa + yi2_r;
  assign hb = pb + yi2_r;

  fgnh_perm_mem u_perm_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ld2_r.ld),
    .wr_addr  (ld2_r.idx),
    .wr_data  (ld2_r.val),
    .rd_addr0 (ha),
    .rd_addr1 (ha + 8'd1),
    .rd_data0 (haa),
    .rd_data1 (hab)
  );

  fgnh_perm_mem u_perm_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ld2_r.ld),
    .wr_addr  (ld2_r.idx),
    .wr_data  (ld2_r.val),
    .rd_addr0 (hb),
    .rd_addr1 (hb + 8'd1),
    .rd_data0 (hba),
    .rd_data1 (hbb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    fx3_r  <= fx2_r;
    fy3_r  <= fy2_r;
    t3x3_r <= sq_frac(ttx2_r, fx2_r);
    t3y3_r <= sq_frac(tty2_r, fy2_r);
    inx3_r <= trunc_fx(ptx2_r) + TEN;
    iny3_r <= trunc_fx(pty2_r) + TEN;
  end

  // Stage 4: corner gradients and the finished fade weights.
  fx_t  x0, y0, x1, y1;
  fx_t  gaa4_r, gba4_r, gab4_r, gbb4_r, u4_r, v4_r;
  logic vld4_r;

  assign x0 = fx_t'(fx3_r);
  assign y0 = fx_t'(fy3_r);
  assign x1 = x0 - ONE;
  assign y1 = y0 - ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    gaa4_r <= grad(haa, x0, y0);
    gba4_r <= grad(hba, x1, y0);
    gab4_r <= grad(hab, x0, y1);
    gbb4_r <= grad(hbb, x1, y1);
    u4_r   <= trunc_fx(prod_t'($signed(PW'(t3x3_r))) * prod_t'(inx3_r));
    v4_r   <= trunc_fx(prod_t'($signed(PW'(t3y3_r))) * prod_t'(iny3_r));
  end

  // Stage 5: products of the two blends along x.
  prod_t p0_5_r, p1_5_r;
  fx_t   gaa5_r, gab5_r, v5_r;
  logic  vld5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= vld4_r;
    end
    p0_5_r <= prod_t'(u4_r) * (prod_t'(gba4_r) - prod_t'(gaa4_r));
    p1_5_r <= prod_t'(u4_r) * (prod_t'(gbb4_r) - prod_t'(gab4_r));
    gaa5_r <= gaa4_r;
    gab5_r <= gab4_r;
    v5_r   <= v4_r;
  end

  // Stage 6: finish the blends along x.
  fx_t  lx0_6_r, lx1_6_r, v6_r;
  logic vld6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else begin
      vld6_r <= vld5_r;
    end
    lx0_6_r <= gaa5_r + trunc_fx(p0_5_r);
    lx1_6_r <= gab5_r + trunc_fx(p1_5_r);
    v6_r    <= v5_r;
  end

  // Stage 7: product of the blend along y.
  prod_t p2_7_r;
  fx_t   lx0_7_r;
  logic  vld7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r <= 1'b0;
    end else begin
      vld7_r <= vld6_r;
    end
    p2_7_r  <= prod_t'(v6_r) * (prod_t'(lx1_6_r) - prod_t'(lx0_6_r));
    lx0_7_r <= lx0_6_r;
  end

  // Stage 8: noise value of this octave.
  fx_t  nz8_r;
  logic vld8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld8_r <= 1'b0;
    end else begin
      vld8_r <= vld7_r;
    end
    nz8_r <= lx0_7_r + trunc_fx(p2_7_r);
  end

  // Stages 9 and 10: apply the octave weight.
  prod_t pw9_r;
  fx_t   term_r;
  logic  vld9_r, vld10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld9_r  <= 1'b0;
      vld10_r <= 1'b0;
    end else begin
      vld9_r  <= vld8_r;
      vld10_r <= vld9_r;
    end
    pw9_r  <= prod_t'(nz8_r) * prod_t'(AMP);
    term_r <= trunc_fx(pw9_r);
  end

  assign term_vld = vld10_r;
  assign term     = term_r;

endmodule

FILE: hdl/fgnh_norm.sv
`timescale 1ns / 1ps
// ============================================================================
// fgnh_norm
// Sums the octave terms, divides by the weight sum with a reciprocal
// multiply and one correction step, and maps the result to a clamped
// Q5.16 height. Six register stages.
// ============================================================================
module fgnh_norm #(
  parameter int OCTAVE_COUNT = fgnh_pkg::OCTAVES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              term_vld,
  input  fgnh_pkg::fx_t     term [OCTAVE_COUNT],
  output logic              height_vld,
  output fgnh_pkg::height_t height
);
  import fgnh_pkg::*;

  localparam longint ASUM  = amp_sum(OCTAVE_COUNT);
  localparam longint RECIP = (longint'(1) << 48) / ASUM;
  localparam int     RW    = 56;
  localparam int     DW    = 40;
  localparam int     QW    = FXW;
  localparam fx_t    ONE   = fx_t'(FX_ONE);

  // Stage 1: sum of the weighted octave terms.
  fx_t  total;
  fx_t  tot1_r;
  logic vld1_r;

  always_comb begin
    total = '0;
    for (int i = 0; i < OCTAVE_COUNT; i++) begin
      total = total + term[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= term_vld;
    end
    tot1_r <= total;
  end

  // Stage 2: magnitude times the reciprocal of the weight sum.
  logic [QW-1:0] mag;
  logic [RW-1:0] prod2_r;
  logic [QW-1:0] mag2_r;
  logic          neg2_r, vld2_r;

  assign mag = tot1_r[FXW-1] ? QW'(-tot1_r) : QW'(tot1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    prod2_r <= RW'(mag) * RW'(RECIP);
    mag2_r  <= mag;
    neg2_r  <= tot1_r[FXW-1];
  end

  // Stage 3: the quotient estimate and its product with the divisor.
  logic [QW-1:0] est;
  logic [QW-1:0] est3_r, mag3_r;
  logic [DW-1:0] estd3_r;
  logic          neg3_r, vld3_r;

  assign est = prod2_r[32 +: QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    est3_r  <= est;
    estd3_r <= DW'(est) * DW'(ASUM);
    mag3_r  <= mag2_r;
    neg3_r  <= neg2_r;
  end

  // Stage 4: the estimate is at most one short; fix it and restore the sign.
  logic [DW-1:0] rem;
  logic [QW-1:0] quo;
  fx_t           n4_r;
  logic          vld4_r;

  assign rem = (DW'(mag3_r) << FRAC_BITS) - estd3_r;
  assign quo = est3_r + QW'(rem >= DW'(ASUM));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    n4_r <= neg3_r ? -fx_t'(quo) : fx_t'(quo);
  end

  // Stage 5: shift to [0,2] and scale by 12.75.
  fx_t   shifted;
  prod_t hp5_r;
  logic  pos5_r, vld5_r;

  assign shifted = n4_r + ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= vld4_r;
    end
    hp5_r  <= prod_t'(shifted) * prod_t'(HEIGHT_MUL);
    pos5_r <= !shifted[FXW-1] && (shifted != '0);
  end

  // Stage 6: clamp into the height range.
  prod_t   hv;
  height_t out_r;
  logic    vld6_r;

  assign hv = hp5_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else begin
      vld6_r <= vld5_r;
    end
    if (!pos5_r) begin
      out_r <= '0;
    end else if (hv > prod_t'(HEIGHT_MAX)) begin
      out_r <= HW'(HEIGHT_MAX);
    end else begin
      out_r <= HW'(hv);
    end
  end

  assign height_vld = vld6_r;
  assign height     = out_r;

endmodule
